FILE: hdl/gmaf_pkg.sv
// Shared constants and types of the gated moving average filter.
package gmaf_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int AVG_W      = 10;
	localparam int THR_W      = 11;
	localparam int WINDOW_LEN = 25;
	localparam int SAMPLE_MAX = (2 ** SAMPLE_W) - 1;
	localparam int SLOT_W     = $clog2(WINDOW_LEN + 1);
	localparam int IDX_W      = $clog2(WINDOW_LEN);
	localparam int SUM_W      = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);
	localparam int CNT_W      = $clog2(SUM_W + 1);
	localparam int TDATA_W    = 16;
	localparam int TUSER_W    = 2;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(200);

	typedef struct packed {
		logic in_ready;
		logic load;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic acc;
		logic div_done;
		logic out_valid;
		logic out_free;
	} status_t;

endpackage

FILE: hdl/gated_moving_average_filter_unit.sv
// Top level of the gated moving average filter.
// Each input item carries one converter sample; samples strictly below the threshold
// register (reset 200; the user must write it through cfg_wr_en/cfg_wr_data only while
// idle, which the block does not enforce) enter a 25-slot circular window, and every
// item returns one result with the held average, the accepted flag and the window-full
// flag. An accepted sample passes from acceptance to the result register through
// divider start, the 15 steps of the bit-serial divider, average capture and output
// load; a rejected sample skips the divider and goes to output load. The divider
// retires one quotient bit per cycle over the width of the running sum. The next item
// is taken the cycle after the result enters the output register, even if it has not
// yet been taken downstream, so no new item is taken while the last is in flight; a
// result that finds the output register still occupied waits until it is taken.
module gated_moving_average_filter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [gmaf_pkg::THR_W-1:0]     cfg_wr_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [gmaf_pkg::TDATA_W-1:0]   s_axis_tdata,  // [9:0] sample
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [gmaf_pkg::TDATA_W-1:0]   m_axis_tdata,  // [9:0] average
	output logic [gmaf_pkg::TUSER_W-1:0]   m_axis_tuser   // [0] accepted, [1] window_full
);

	gmaf_pkg::cmd_t                cmd;
	gmaf_pkg::status_t             st;
	logic [gmaf_pkg::AVG_W-1:0]    average;
	logic                          accepted;
	logic                          window_full;

	gmaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.st       (st),
		.cmd      (cmd)
	);

	gmaf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.sample          (s_axis_tdata[gmaf_pkg::SAMPLE_W-1:0]),
		.out_ready       (m_axis_tready),
		.cmd             (cmd),
		.st              (st),
		.out_average     (average),
		.out_accepted    (accepted),
		.out_window_full (window_full)
	);

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tvalid = st.out_valid;
	assign m_axis_tdata  = {{(gmaf_pkg::TDATA_W - gmaf_pkg::AVG_W){1'b0}}, average};
	assign m_axis_tuser  = {window_full, accepted};

endmodule

FILE: hdl/gmaf_div.sv
// Bit-serial restoring divider for the window average.
module gmaf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gmaf_pkg::SUM_W-1:0]    dividend,
	input  logic [gmaf_pkg::SLOT_W-1:0]   divisor,
	output logic                          done,
	output logic [gmaf_pkg::SUM_W-1:0]    quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [gmaf_pkg::CNT_W-1:0]    cnt_q;
	logic [gmaf_pkg::SLOT_W-1:0]   rem_q;
	logic [gmaf_pkg::SUM_W-1:0]    quo_q;
	logic [gmaf_pkg::SLOT_W:0]     trial;
	logic [gmaf_pkg::SLOT_W:0]     diff;
	logic                          qbit;

	always_comb begin
		trial = {rem_q, quo_q[gmaf_pkg::SUM_W-1]};
		diff  = trial - {1'b0, divisor};
		qbit  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= gmaf_pkg::CNT_W'(gmaf_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == gmaf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[gmaf_pkg::SUM_W-2:0], qbit};
			rem_q <= qbit ? diff[gmaf_pkg::SLOT_W-1:0] : trial[gmaf_pkg::SLOT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/gmaf_dp.sv
// Datapath: threshold gate, window store, running sum, divider and output register.
module gmaf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gmaf_pkg::THR_W-1:0]    cfg_wr_data,
	input  logic [gmaf_pkg::SAMPLE_W-1:0] sample,
	input  logic                          out_ready,
	input  gmaf_pkg::cmd_t                cmd,
	output gmaf_pkg::status_t             st,
	output logic [gmaf_pkg::AVG_W-1:0]    out_average,
	output logic                          out_accepted,
	output logic                          out_window_full
);

	logic [gmaf_pkg::THR_W-1:0]    thr_q;
	logic [gmaf_pkg::SAMPLE_W-1:0] store_q [gmaf_pkg::WINDOW_LEN];
	logic [gmaf_pkg::SUM_W-1:0]    sum_q;
	logic [gmaf_pkg::SLOT_W-1:0]   slot_q;
	logic                          wrapped_q;
	logic                          acc_q;
	logic [gmaf_pkg::SLOT_W-1:0]   divisor_q;
	logic [gmaf_pkg::AVG_W-1:0]    held_avg_q;
	logic                          out_valid_q;
	logic [gmaf_pkg::AVG_W-1:0]    out_avg_q;
	logic                          out_acc_q;
	logic                          out_full_q;

	logic                          at_end;
	logic [gmaf_pkg::SLOT_W-1:0]   slot_eff;
	logic [gmaf_pkg::IDX_W-1:0]    idx;
	logic                          wrapped_eff;
	logic                          gate;
	logic [gmaf_pkg::SAMPLE_W-1:0] old_val;
	logic [gmaf_pkg::SUM_W-1:0]    new_sum;
	logic                          div_done;
	logic [gmaf_pkg::SUM_W-1:0]    quotient;

	always_comb begin
		at_end      = (slot_q == gmaf_pkg::SLOT_W'(gmaf_pkg::WINDOW_LEN));
		slot_eff    = at_end ? '0 : slot_q;
		idx         = slot_eff[gmaf_pkg::IDX_W-1:0];
		wrapped_eff = wrapped_q | at_end;
		gate        = (gmaf_pkg::THR_W'(sample) < thr_q);
		old_val     = store_q[idx];
		new_sum     = sum_q - gmaf_pkg::SUM_W'(old_val) + gmaf_pkg::SUM_W'(sample);
	end

	gmaf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= gmaf_pkg::THR_RESET;
			sum_q       <= '0;
			slot_q      <= '0;
			wrapped_q   <= 1'b0;
			acc_q       <= 1'b0;
			held_avg_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < gmaf_pkg::WINDOW_LEN; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				slot_q    <= slot_eff + gmaf_pkg::SLOT_W'(1);
				wrapped_q <= wrapped_eff;
				acc_q     <= gate;
				if (gate) begin
					store_q[idx] <= sample;
					sum_q        <= new_sum;
				end
			end
			if (div_done) begin
				held_avg_q <= quotient[gmaf_pkg::AVG_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			divisor_q <= wrapped_eff ? gmaf_pkg::SLOT_W'(gmaf_pkg::WINDOW_LEN)
			                         : slot_eff + gmaf_pkg::SLOT_W'(1);
		end
		if (cmd.out_load) begin
			out_avg_q  <= held_avg_q;
			out_acc_q  <= acc_q;
			out_full_q <= wrapped_q;
		end
	end

	assign st.acc       = acc_q;
	assign st.div_done  = div_done;
	assign st.out_valid = out_valid_q;
	assign st.out_free  = !out_valid_q || out_ready;

	assign out_average     = out_avg_q;
	assign out_accepted    = out_acc_q;
	assign out_window_full = out_full_q;

`ifndef SYNTH
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= gmaf_pkg::SLOT_W'(gmaf_pkg::WINDOW_LEN))
		else $error("slot position beyond window length");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!wrapped_q |-> (32'(sum_q) <= 32'(slot_q) * 32'(gmaf_pkg::SAMPLE_MAX)))
		else $error("running sum exceeds filled slots before wrap");

	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!div_done |=> $stable(held_avg_q))
		else $error("held average changed without a finished division");
`endif

endmodule

FILE: hdl/gmaf_ctrl.sv
// Controller state machine sequencing load, divide and output.
module gmaf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  gmaf_pkg::status_t st,
	output gmaf_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_START  = 4'b0010,
		S_DIVIDE = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt     = state_q;
		cmd.in_ready  = 1'b0;
		cmd.load      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_START;
				end
			end
			S_START: begin
				if (st.acc) begin
					cmd.div_start = 1'b1;
					state_nxt     = S_DIVIDE;
				end else begin
					state_nxt = S_EMIT;
				end
			end
			S_DIVIDE: begin
				if (st.div_done) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef SYNTH
	a_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> st.acc)
		else $error("divider started for a rejected sample");

	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> state_q == S_DIVIDE)
		else $error("divider finished outside the divide state");

	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> st.out_valid)
		else $error("output register not valid after load");
`endif

endmodule

FILE: bench/tb.sv
// Testbench for the gated moving average filter unit.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [gmaf_pkg::AVG_W-1:0] average;
		logic                       accepted;
		logic                       window_full;
	} avg_result_t;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           cfg_wr_en     = 1'b0;
	logic [gmaf_pkg::THR_W-1:0]     cfg_wr_data   = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic [gmaf_pkg::TDATA_W-1:0]   s_axis_tdata  = '0;
	logic                           m_axis_tready = 1'b0;
	logic                           s_axis_tready;
	logic                           m_axis_tvalid;
	logic [gmaf_pkg::TDATA_W-1:0]   m_axis_tdata;
	logic [gmaf_pkg::TUSER_W-1:0]   m_axis_tuser;

	gated_moving_average_filter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// filter state mirror
	logic [gmaf_pkg::THR_W-1:0]    threshold_q;
	logic [gmaf_pkg::SAMPLE_W-1:0] window_q [gmaf_pkg::WINDOW_LEN];
	logic [15:0]                   window_sum;
	logic [gmaf_pkg::SLOT_W-1:0]   slot_pos;
	logic                          wrapped;
	logic [gmaf_pkg::AVG_W-1:0]    held_avg;

	avg_result_t expected_q [$];
	int          errors      = 0;
	int          cycle_count = 0;

	bit rx_random = 1'b0;
	bit gaps_on   = 1'b0;
	int hold_req  = 0;
	int hold_left = 0;
	int rx_run    = 0;
	bit rx_on     = 1'b1;
	int burst_left = 0;

	task automatic reset_filter_state();
		for (int i = 0; i < gmaf_pkg::WINDOW_LEN; i++) window_q[i] = '0;
		window_sum  = '0;
		slot_pos    = '0;
		wrapped     = 1'b0;
		held_avg    = '0;
		threshold_q = gmaf_pkg::THR_RESET;
	endtask

	function automatic avg_result_t predict_average(input logic [gmaf_pkg::SAMPLE_W-1:0] s);
		avg_result_t r;
		logic        pass;
		int unsigned divisor;
		if (slot_pos >= gmaf_pkg::SLOT_W'(gmaf_pkg::WINDOW_LEN)) begin
			slot_pos = '0;
			wrapped  = 1'b1;
		end
		pass = ({1'b0, s} < threshold_q);
		if (pass) begin
			window_sum = window_sum - 16'(window_q[slot_pos]) + 16'(s);
			window_q[slot_pos] = s;
			divisor = wrapped ? gmaf_pkg::WINDOW_LEN : int'(slot_pos) + 1;
			held_avg = gmaf_pkg::AVG_W'(int'(window_sum) / divisor);
		end
		slot_pos = slot_pos + 1'b1;
		r.average     = held_avg;
		r.accepted    = pass;
		r.window_full = wrapped;
		return r;
	endfunction

	// receiver: always ready or a random ready pattern, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!rx_random) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (rx_run == 0) begin
				rx_on  = !rx_on;
				rx_run = rx_on ? $urandom_range(1, 20) : $urandom_range(1, 8);
			end
			rx_run--;
			m_axis_tready <= rx_on;
		end
	end

	always @(posedge clk) begin : check_result
		avg_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual tdata %h tuser %b",
					$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = expected_q.pop_front();
				if (m_axis_tdata[gmaf_pkg::AVG_W-1:0] !== want.average) begin
					errors++;
					$display("%0t average mismatch: expected %0d actual %0d",
						$time, want.average, m_axis_tdata[gmaf_pkg::AVG_W-1:0]);
				end
				if (m_axis_tuser[0] !== want.accepted) begin
					errors++;
					$display("%0t accepted mismatch: expected %0b actual %0b",
						$time, want.accepted, m_axis_tuser[0]);
				end
				if (m_axis_tuser[1] !== want.window_full) begin
					errors++;
					$display("%0t window_full mismatch: expected %0b actual %0b",
						$time, want.window_full, m_axis_tuser[1]);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_sample(input logic [gmaf_pkg::SAMPLE_W-1:0] s);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= gmaf_pkg::TDATA_W'(s);
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(predict_average(s));
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			if (gaps_on) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
	endtask

	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic drain();
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [gmaf_pkg::THR_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		threshold_q = v;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [gmaf_pkg::SAMPLE_W-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, gmaf_pkg::SAMPLE_MAX);
			1: v = int'(threshold_q) + $urandom_range(0, 6) - 3;
			2: v = $urandom_range(0, 15);
			default: v = $urandom_range(gmaf_pkg::SAMPLE_MAX - 15, gmaf_pkg::SAMPLE_MAX);
		endcase
		if (v < 0) v = 0;
		if (v > gmaf_pkg::SAMPLE_MAX) v = gmaf_pkg::SAMPLE_MAX;
		return gmaf_pkg::SAMPLE_W'(v);
	endfunction

	task automatic run_stream(input int n);
		repeat (n) begin
			pace();
			send_sample(pick_sample());
		end
	endtask

	task automatic test_gate_directed();
		rx_random = 1'b0;
		gaps_on   = 1'b0;
		send_sample(10'd0);
		send_sample(10'd199);
		send_sample(10'd200);
		send_sample(10'd1023);
		send_sample(10'd1);
		send_sample(10'h0AA);
		send_sample(10'h155);
		write_threshold(11'd1024);
		send_sample(10'd1023);
		send_sample(10'h2AA);
		write_threshold(11'd0);
		send_sample(10'd0);
		send_sample(10'd5);
		write_threshold(11'd1023);
		send_sample(10'd1023);
		send_sample(10'd1022);
	endtask

	task automatic test_full_scale();
		write_threshold(11'd1024);
		rx_random = 1'b0;
		gaps_on   = 1'b0;
		repeat (60) send_sample(gmaf_pkg::SAMPLE_W'($urandom_range(gmaf_pkg::SAMPLE_MAX - 23,
			gmaf_pkg::SAMPLE_MAX)));
	endtask

	task automatic test_threshold_sweep();
		logic [gmaf_pkg::THR_W-1:0] levels [9];
		levels = '{11'd1024, 11'd200, 11'd0, 11'd1, 11'd512, 11'd1023,
			gmaf_pkg::THR_W'($urandom_range(0, 1024)),
			gmaf_pkg::THR_W'($urandom_range(0, 1024)),
			gmaf_pkg::THR_W'($urandom_range(0, 1024))};
		rx_random = 1'b1;
		gaps_on   = 1'b1;
		foreach (levels[i]) begin
			write_threshold(levels[i]);
			run_stream(150);
		end
	endtask

	task automatic test_backpressure();
		write_threshold(11'd700);
		gaps_on  = 1'b0;
		hold_req = HOLD_CYCLES;
		run_stream(40);
	endtask

	task automatic test_sender_pause();
		write_threshold(gmaf_pkg::THR_W'($urandom_range(300, 1024)));
		rx_random = 1'b1;
		gaps_on   = 1'b1;
		run_stream(100);
		wait_results();
		run_stream(100);
	endtask

	initial begin
		reset_filter_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_gate_directed();
		test_full_scale();
		test_threshold_sweep();
		test_backpressure();
		test_sender_pause();
		drain();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
